[hdl/pefa_pkg.sv]
// Package for the per-edge flow accumulator: sizes, opcodes, status codes, divider handshake.
// No dependencies.
package pefa_pkg;

  localparam int MaxNodes     = 256;
  localparam int MaxEdges     = 1024;
  localparam int SlotsPerEdge = 16;

  localparam int NodeW  = 8;
  localparam int EdgeW  = $clog2(MaxEdges);
  localparam int CountW = EdgeW + 1;
  localparam int SlotW  = $clog2(SlotsPerEdge);
  localparam int LenW   = SlotW + 1;
  localparam int EntW   = EdgeW + SlotW;
  localparam int ValW   = 32;
  localparam int OutfW  = 40;

  typedef enum logic [1:0] {
    OP_LOAD  = 2'd0,
    OP_ADD   = 2'd1,
    OP_SCALE = 2'd2,
    OP_READ  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_LIST_FULL = 2'd2,
    ST_TABLE_FULL = 2'd3
  } status_t;

  // Divider handshake
  typedef struct packed {
    logic start;
    logic neg;
    logic [ValW-1:0] mag;
    logic [OutfW-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
    logic [ValW-1:0] quot;
  } div_rsp_t;

endpackage

[hdl/pefa_ram.sv]
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module pefa_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hdl/pefa_div.sv]
// Restoring divider: (mag << 16) / den, one quotient bit a cycle, saturated to 32 bits signed.
// Depends on pefa_pkg.
module pefa_div (
  input  logic                clk,
  input  logic                rst_n,
  input  pefa_pkg::div_req_t  req,
  output pefa_pkg::div_rsp_t  rsp
);

  localparam int NumW = pefa_pkg::ValW + 16;
  localparam int CntW = $clog2(NumW + 1);
  localparam int RemW = pefa_pkg::OutfW + 1;

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CntW-1:0]  cnt_r, cnt_nxt;
  logic [NumW-1:0]  num_r, num_nxt;
  logic [RemW-1:0]  rem_r, rem_nxt;
  logic [pefa_pkg::OutfW-1:0] den_r, den_nxt;
  logic             neg_r, neg_nxt;
  logic [RemW-1:0]  trial;
  logic [pefa_pkg::ValW-1:0] quot;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    neg_nxt  = neg_r;
    trial    = {rem_r[RemW-2:0], num_r[NumW-1]};
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CntW'(NumW);
      num_nxt  = {req.mag, 16'd0};
      rem_nxt  = '0;
      den_nxt  = req.den;
      neg_nxt  = req.neg;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = trial - {1'b0, den_r};
        num_nxt = {num_r[NumW-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        num_nxt = {num_r[NumW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CntW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    neg_r <= neg_nxt;
  end

  always_comb begin
    if (neg_r) begin
      if (num_r >= NumW'(64'h8000_0000)) begin
        quot = 32'h8000_0000;
      end else begin
        quot = -num_r[pefa_pkg::ValW-1:0];
      end
    end else begin
      if (num_r > NumW'(64'h7FFF_FFFF)) begin
        quot = 32'h7FFF_FFFF;
      end else begin
        quot = num_r[pefa_pkg::ValW-1:0];
      end
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quot = quot;

endmodule

[hdl/per_edge_flow_accumulator_top.sv]
// Top level of the per-edge flow accumulator: sequencer, memories, one divider for scale.
// Depends on pefa_pkg, pefa_ram, pefa_div.
//
// Usage: one input transaction on in_* produces exactly one result transaction
// on out_*. in_tready is high only while the sequencer is idle and no result
// waits in the output register, so a new item is accepted at the earliest in
// the cycle after the previous result has been taken.
// Steps: a load passes from acceptance through S_OUT to the output register;
// add/read run a binary search through the edge RAM read port, walk the list
// slots (up to SlotsPerEdge) and, for an insert, shift entries (up to
// SlotsPerEdge - 1). Scale visits every stored entry twice through the entry
// RAM read port and starts the divider for each entry whose source outflow is
// nonzero.
// After reset the list-length store is cleared, one edge a cycle, over all
// MaxEdges edges while in_tready stays low; the outflow store is cleared the same way
// at the start of each scale (all MaxNodes nodes). A stalled receiver holds out_tvalid
// and out_tdata stable; the block then stays idle and accepts no new item.
module per_edge_flow_accumulator_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,  // op[1:0], node_a[9:2], node_b[17:10], source[25:18], flow[57:26]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata  // status[1:0], edge_index[11:2], found[12], value[44:13]
);

  localparam int EW = pefa_pkg::EdgeW;
  localparam int CW = pefa_pkg::CountW;
  localparam int SW = pefa_pkg::SlotW;
  localparam int LW = pefa_pkg::LenW;
  localparam int NW = pefa_pkg::EntW;
  localparam int VW = pefa_pkg::ValW;
  localparam int OW = pefa_pkg::OutfW;
  localparam int DW = pefa_pkg::NodeW;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_BS_RD, S_BS_CHK, S_HIT_RD, S_HIT_CHK,
    S_SL_RD, S_SL_CHK, S_SH_RD, S_SH_WR, S_INS, S_UPD,
    S_SC_CLR, S_SC_E, S_SC_ER, S_SC_K, S_SC_KR, S_SC_OR, S_SC_OW,
    S_SC2_E, S_SC2_ER, S_SC2_K, S_SC2_KR, S_SC2_OR, S_SC2_DV, S_SC2_WT,
    S_OUT
  } state_t;

  state_t state_r, state_nxt;

  // Input fields
  pefa_pkg::op_t   in_op;
  logic [DW-1:0]   in_a, in_b, in_src;
  logic [VW-1:0]   in_flow;
  assign in_op   = pefa_pkg::op_t'(in_tdata[1:0]);
  assign in_a    = in_tdata[9:2];
  assign in_b    = in_tdata[17:10];
  assign in_src  = in_tdata[25:18];
  assign in_flow = in_tdata[57:26];

  // Registers
  pefa_pkg::op_t op_r, op_nxt;
  logic [DW-1:0] a_r, a_nxt, b_r, b_nxt, src_r, src_nxt;
  logic [VW-1:0] flow_r, flow_nxt;
  logic [CW-1:0] ecnt_r, ecnt_nxt;
  logic [CW-1:0] lo_r, lo_nxt, hi_r, hi_nxt;
  logic [CW-1:0] e_r, e_nxt;
  logic [LW-1:0] k_r, k_nxt, len_r, len_nxt, j_r, j_nxt;
  logic [CW-1:0] clr_r, clr_nxt;
  logic [DW-1:0] lend_r, lend_nxt, hend_r, hend_nxt;
  logic [1:0]    ost_r, ost_nxt;
  logic [EW-1:0] oidx_r, oidx_nxt;
  logic          ofnd_r, ofnd_nxt;
  logic [VW-1:0] oval_r, oval_nxt;
  logic          ovalid_r, ovalid_nxt;
  logic [DW-1:0] esrc_r, esrc_nxt;

  // Memories
  logic          edge_we;
  logic [EW-1:0] edge_wa, edge_ra;
  logic [2*DW-1:0] edge_wd, edge_rd;
  logic          len_we;
  logic [EW-1:0] len_wa, len_ra;
  logic [LW-1:0] len_wd, len_rd;
  logic          ent_we;
  logic [NW-1:0] ent_wa, ent_ra;
  logic [DW+VW-1:0] ent_wd, ent_rd;
  logic          of_we;
  logic [DW-1:0] of_wa, of_ra;
  logic [OW-1:0] of_wd, of_rd;

  pefa_ram #(.Width(2*DW), .Depth(pefa_pkg::MaxEdges)) u_edge_ram (
    .clk(clk), .we(edge_we), .waddr(edge_wa), .wdata(edge_wd), .raddr(edge_ra), .rdata(edge_rd));
  pefa_ram #(.Width(LW), .Depth(pefa_pkg::MaxEdges)) u_len_ram (
    .clk(clk), .we(len_we), .waddr(len_wa), .wdata(len_wd), .raddr(len_ra), .rdata(len_rd));
  pefa_ram #(.Width(DW+VW), .Depth(pefa_pkg::MaxEdges*pefa_pkg::SlotsPerEdge)) u_ent_ram (
    .clk(clk), .we(ent_we), .waddr(ent_wa), .wdata(ent_wd), .raddr(ent_ra), .rdata(ent_rd));
  pefa_ram #(.Width(OW), .Depth(pefa_pkg::MaxNodes)) u_of_ram (
    .clk(clk), .we(of_we), .waddr(of_wa), .wdata(of_wd), .raddr(of_ra), .rdata(of_rd));

  pefa_pkg::div_req_t div_req;
  pefa_pkg::div_rsp_t div_rsp;
  pefa_div u_div (.clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp));

  // Helpers
  logic [CW-1:0] mid;
  logic [DW-1:0] eu, ev, rs;
  logic [VW-1:0] rv;
  logic          less;
  logic [VW:0]   sum;
  logic [VW-1:0] sat;
  logic [OW:0]   osum;
  logic [VW:0]   fmag;
  logic          contrib;

  assign mid  = CW'(({1'b0, lo_r} + {1'b0, hi_r}) >> 1);
  assign eu   = edge_rd[2*DW-1:DW];
  assign ev   = edge_rd[DW-1:0];
  assign rs   = ent_rd[DW+VW-1:VW];
  assign rv   = ent_rd[VW-1:0];
  assign less = (eu < a_r) || (eu == a_r && ev < b_r);
  assign sum  = {rv[VW-1], rv} + {flow_r[VW-1], flow_r};
  assign sat  = (sum[VW] != sum[VW-1]) ? (sum[VW] ? 32'h8000_0000 : 32'h7FFF_FFFF)
                                       : sum[VW-1:0];
  assign fmag = rv[VW-1] ? -{rv[VW-1], rv} : {1'b0, rv};
  assign contrib = rv[VW-1] ? (rs == hend_r) : (rs == lend_r);
  assign osum = {1'b0, of_rd} + (contrib ? (OW+1)'(fmag) : '0);

  logic in_fire;
  assign in_tready = (state_r == S_IDLE) && !ovalid_r;
  assign in_fire   = in_tvalid && in_tready;

  always_comb begin
    state_nxt = state_r;
    op_nxt = op_r; a_nxt = a_r; b_nxt = b_r; src_nxt = src_r; flow_nxt = flow_r;
    ecnt_nxt = ecnt_r; lo_nxt = lo_r; hi_nxt = hi_r; e_nxt = e_r;
    k_nxt = k_r; len_nxt = len_r; j_nxt = j_r; clr_nxt = clr_r;
    lend_nxt = lend_r; hend_nxt = hend_r;
    ost_nxt = ost_r; oidx_nxt = oidx_r; ofnd_nxt = ofnd_r; oval_nxt = oval_r;
    ovalid_nxt = ovalid_r;
    esrc_nxt = esrc_r;
    edge_we = 1'b0; edge_wa = e_r[EW-1:0]; edge_wd = {a_r, b_r}; edge_ra = mid[EW-1:0];
    len_we = 1'b0; len_wa = e_r[EW-1:0]; len_wd = '0; len_ra = e_r[EW-1:0];
    ent_we = 1'b0; ent_wa = {e_r[EW-1:0], k_r[SW-1:0]}; ent_wd = {src_r, flow_r};
    ent_ra = {e_r[EW-1:0], k_r[SW-1:0]};
    of_we = 1'b0; of_wa = clr_r[DW-1:0]; of_wd = '0; of_ra = rs;
    div_req.start = 1'b0;
    div_req.neg   = rv[VW-1];
    div_req.mag   = fmag[VW-1:0];
    div_req.den   = of_rd;

    if (ovalid_r && out_tready) begin
      ovalid_nxt = 1'b0;
    end

    unique case (state_r)
      S_CLR: begin
        len_we = 1'b1; len_wa = clr_r[EW-1:0]; len_wd = '0;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == CW'(pefa_pkg::MaxEdges - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_fire) begin
          op_nxt = in_op;
          a_nxt = (in_a < in_b) ? in_a : in_b;
          b_nxt = (in_a < in_b) ? in_b : in_a;
          src_nxt = in_src; flow_nxt = in_flow;
          ost_nxt = pefa_pkg::ST_OK; oidx_nxt = '0; ofnd_nxt = 1'b0; oval_nxt = '0;
          lo_nxt = '0; hi_nxt = ecnt_r; clr_nxt = '0;
          unique case (in_op)
            pefa_pkg::OP_LOAD: begin
              if (ecnt_r >= CW'(pefa_pkg::MaxEdges)) begin
                ost_nxt = pefa_pkg::ST_TABLE_FULL;
                state_nxt = S_OUT;
              end else begin
                edge_we = 1'b1; edge_wa = ecnt_r[EW-1:0];
                edge_wd = {((in_a < in_b) ? in_a : in_b), ((in_a < in_b) ? in_b : in_a)};
                len_we = 1'b1; len_wa = ecnt_r[EW-1:0]; len_wd = '0;
                oidx_nxt = ecnt_r[EW-1:0];
                ecnt_nxt = ecnt_r + 1'b1;
                state_nxt = S_OUT;
              end
            end
            pefa_pkg::OP_SCALE: state_nxt = S_SC_CLR;
            pefa_pkg::OP_ADD,
            pefa_pkg::OP_READ:  state_nxt = S_BS_RD;
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_BS_RD: begin
        if (lo_r < hi_r) begin
          edge_ra = mid[EW-1:0];
          e_nxt = mid;
          state_nxt = S_BS_CHK;
        end else if (lo_r < ecnt_r) begin
          edge_ra = lo_r[EW-1:0];
          e_nxt = lo_r;
          state_nxt = S_HIT_RD;
        end else begin
          ost_nxt = pefa_pkg::ST_NOT_FOUND;
          state_nxt = S_OUT;
        end
      end
      S_BS_CHK: begin
        if (less) lo_nxt = e_r + 1'b1;
        else      hi_nxt = e_r;
        state_nxt = S_BS_RD;
      end
      S_HIT_RD: begin
        len_ra = e_r[EW-1:0];
        state_nxt = S_HIT_CHK;
      end
      S_HIT_CHK: begin
        if (eu == a_r && ev == b_r) begin
          oidx_nxt = e_r[EW-1:0];
          len_nxt = len_rd;
          k_nxt = '0;
          state_nxt = S_SL_RD;
        end else begin
          ost_nxt = pefa_pkg::ST_NOT_FOUND;
          state_nxt = S_OUT;
        end
      end
      S_SL_RD: begin
        if (k_r < len_r) begin
          ent_ra = {e_r[EW-1:0], k_r[SW-1:0]};
          state_nxt = S_SL_CHK;
        end else begin
          state_nxt = S_UPD;
        end
      end
      S_SL_CHK: begin
        if (rs < src_r) begin
          k_nxt = k_r + 1'b1;
          state_nxt = S_SL_RD;
        end else if (rs == src_r) begin
          if (op_r == pefa_pkg::OP_READ) begin
            ofnd_nxt = 1'b1; oval_nxt = rv;
          end else begin
            oval_nxt = sat;
            ent_we = 1'b1; ent_wd = {src_r, sat};
          end
          state_nxt = S_OUT;
        end else begin
          state_nxt = S_UPD;
        end
      end
      S_UPD: begin
        if (op_r == pefa_pkg::OP_READ) begin
          state_nxt = S_OUT;
        end else if (len_r >= LW'(pefa_pkg::SlotsPerEdge)) begin
          ost_nxt = pefa_pkg::ST_LIST_FULL;
          state_nxt = S_OUT;
        end else begin
          j_nxt = len_r;
          state_nxt = S_SH_RD;
        end
      end
      S_SH_RD: begin
        if (j_r > k_r) begin
          ent_ra = {e_r[EW-1:0], SW'(j_r - 1'b1)};
          state_nxt = S_SH_WR;
        end else begin
          state_nxt = S_INS;
        end
      end
      S_SH_WR: begin
        ent_we = 1'b1; ent_wa = {e_r[EW-1:0], j_r[SW-1:0]}; ent_wd = ent_rd;
        j_nxt = j_r - 1'b1;
        state_nxt = S_SH_RD;
      end
      S_INS: begin
        ent_we = 1'b1; ent_wd = {src_r, flow_r};
        len_we = 1'b1; len_wd = len_r + 1'b1;
        oval_nxt = flow_r;
        state_nxt = S_OUT;
      end
      S_SC_CLR: begin
        of_we = 1'b1; of_wa = clr_r[DW-1:0]; of_wd = '0;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == CW'(pefa_pkg::MaxNodes - 1)) begin
          e_nxt = '0;
          state_nxt = S_SC_E;
        end
      end
      S_SC_E: begin
        if (e_r < ecnt_r) begin
          edge_ra = e_r[EW-1:0]; len_ra = e_r[EW-1:0];
          state_nxt = S_SC_ER;
        end else begin
          e_nxt = '0;
          state_nxt = S_SC2_E;
        end
      end
      S_SC_ER: begin
        lend_nxt = eu; hend_nxt = ev; len_nxt = len_rd; k_nxt = '0;
        state_nxt = S_SC_K;
      end
      S_SC_K: begin
        if (k_r < len_r) begin
          ent_ra = {e_r[EW-1:0], k_r[SW-1:0]};
          state_nxt = S_SC_KR;
        end else begin
          e_nxt = e_r + 1'b1;
          state_nxt = S_SC_E;
        end
      end
      S_SC_KR: begin
        of_ra = rs;
        state_nxt = S_SC_OR;
      end
      S_SC_OR: begin
        of_we = 1'b1; of_wa = rs;
        of_wd = osum[OW] ? {OW{1'b1}} : osum[OW-1:0];
        k_nxt = k_r + 1'b1;
        state_nxt = S_SC_K;
      end
      S_SC2_E: begin
        if (e_r < ecnt_r) begin
          len_ra = e_r[EW-1:0];
          state_nxt = S_SC2_ER;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_SC2_ER: begin
        len_nxt = len_rd; k_nxt = '0;
        state_nxt = S_SC2_K;
      end
      S_SC2_K: begin
        if (k_r < len_r) begin
          ent_ra = {e_r[EW-1:0], k_r[SW-1:0]};
          state_nxt = S_SC2_KR;
        end else begin
          e_nxt = e_r + 1'b1;
          state_nxt = S_SC2_E;
        end
      end
      S_SC2_KR: begin
        of_ra = rs;
        state_nxt = S_SC2_OR;
      end
      S_SC2_OR: begin
        esrc_nxt = rs;
        if (of_rd == '0) begin
          k_nxt = k_r + 1'b1;
          state_nxt = S_SC2_K;
        end else begin
          div_req.start = 1'b1;
          state_nxt = S_SC2_DV;
        end
      end
      S_SC2_DV: begin
        if (div_rsp.done) begin
          ent_we = 1'b1; ent_wd = {esrc_r, div_rsp.quot};
          k_nxt = k_r + 1'b1;
          state_nxt = S_SC2_WT;
        end
      end
      S_SC2_WT: begin
        state_nxt = S_SC2_K;
      end
      S_OUT: begin
        if (!ovalid_r) begin
          ovalid_nxt = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_CLR;
      ecnt_r   <= '0;
      clr_r    <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ecnt_r   <= ecnt_nxt;
      clr_r    <= clr_nxt;
      ovalid_r <= ovalid_nxt;
    end
    op_r <= op_nxt; a_r <= a_nxt; b_r <= b_nxt; src_r <= src_nxt; flow_r <= flow_nxt;
    lo_r <= lo_nxt; hi_r <= hi_nxt; e_r <= e_nxt;
    k_r <= k_nxt; len_r <= len_nxt; j_r <= j_nxt;
    lend_r <= lend_nxt; hend_r <= hend_nxt;
    ost_r <= ost_nxt; oidx_r <= oidx_nxt; ofnd_r <= ofnd_nxt; oval_r <= oval_nxt;
    esrc_r <= esrc_nxt;
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = {3'd0, oval_r, ofnd_r, oidx_r, ost_r};

  // Checks
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |-> !out_tvalid)
    else $error("input accepted while result pending");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result dropped under stall");
  a_ecnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ecnt_r <= CW'(pefa_pkg::MaxEdges))
    else $error("edge count overflow");
  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> !div_rsp.busy)
    else $error("divider restarted while busy");

endmodule

[sim/per_edge_flow_accumulator_top_tb.sv]
// Testbench for per_edge_flow_accumulator_top: a directed table, then random and stress traffic.
// Results are checked against given values or a model of the edge table and sorted flow lists.
// Depends on pefa_pkg and the RTL of per_edge_flow_accumulator_top.
module per_edge_flow_accumulator_top_tb;

  localparam int WatchdogLimit = 400000;
  localparam int HotEdges      = 24;

  typedef struct packed {
    logic [31:0]   flow;
    logic [7:0]    source;
    logic [7:0]    node_b;
    logic [7:0]    node_a;
    pefa_pkg::op_t op;
  } flow_item_t;

  typedef struct packed {
    logic [31:0] value;
    logic        found;
    logic [9:0]  edge_index;
    logic [1:0]  status;
  } flow_result_t;

  typedef struct {
    flow_item_t   item;
    bit           typed;
    flow_result_t want;
  } table_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;

  logic [7:0]  edge_lo [pefa_pkg::MaxEdges];
  logic [7:0]  edge_hi [pefa_pkg::MaxEdges];
  int          edge_total;
  int          list_len [pefa_pkg::MaxEdges];
  logic [7:0]  slot_src [pefa_pkg::MaxEdges][pefa_pkg::SlotsPerEdge];
  logic [31:0] slot_val [pefa_pkg::MaxEdges][pefa_pkg::SlotsPerEdge];

  flow_result_t expected_results[$];
  table_row_t   directed_rows[$];
  int  errors = 0;
  int  items_sent = 0;
  int  results_seen = 0;
  int  idle_cycles = 0;
  bit  no_idle = 1'b0;
  bit  hold_req = 1'b0;
  int  hold_cnt = 0;
  int  next_key = 3 * 256 + 4;

  per_edge_flow_accumulator_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  always #10 clk = ~clk;

  function automatic logic [31:0] scale_flow(logic [31:0] v, longint unsigned d);
    longint unsigned mag;
    longint unsigned q;
    bit neg;
    neg = v[31];
    mag = neg ? longint'(-longint'($signed(v))) : longint'(v);
    q = (mag << 16) / d;
    if (neg) return (q >= 64'h8000_0000) ? 32'h8000_0000 : 32'(-longint'(q));
    return (q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : 32'(q);
  endfunction

  function automatic void rescale_flows();
    longint unsigned outflow [pefa_pkg::MaxNodes];
    longint unsigned add;
    logic [7:0] s;
    logic [31:0] f;
    for (int n = 0; n < pefa_pkg::MaxNodes; n++) outflow[n] = 0;
    for (int e = 0; e < edge_total; e++) begin
      for (int k = 0; k < list_len[e]; k++) begin
        s = slot_src[e][k];
        f = slot_val[e][k];
        add = 0;
        if (!f[31]) begin
          if (s == edge_lo[e]) add = longint'(f);
        end else if (s == edge_hi[e]) begin
          add = longint'(-longint'($signed(f)));
        end
        outflow[s] += add;
        if (outflow[s] > 64'hFF_FFFF_FFFF) outflow[s] = 64'hFF_FFFF_FFFF;
      end
    end
    for (int e = 0; e < edge_total; e++)
      for (int k = 0; k < list_len[e]; k++)
        if (outflow[slot_src[e][k]] != 0)
          slot_val[e][k] = scale_flow(slot_val[e][k], outflow[slot_src[e][k]]);
  endfunction

  function automatic flow_result_t apply_item(flow_item_t it);
    flow_result_t r;
    logic [7:0] a;
    logic [7:0] b;
    int lo;
    int hi;
    int mid;
    int k;
    int len;
    bit hit;
    longint sum;
    r = '0;
    a = (it.node_a < it.node_b) ? it.node_a : it.node_b;
    b = (it.node_a < it.node_b) ? it.node_b : it.node_a;
    if (it.op == pefa_pkg::OP_LOAD) begin
      if (edge_total >= pefa_pkg::MaxEdges) begin
        r.status = pefa_pkg::ST_TABLE_FULL;
      end else begin
        edge_lo[edge_total] = a;
        edge_hi[edge_total] = b;
        list_len[edge_total] = 0;
        r.edge_index = 10'(edge_total);
        edge_total++;
      end
    end else if (it.op == pefa_pkg::OP_SCALE) begin
      rescale_flows();
    end else begin
      lo = 0;
      hi = edge_total;
      while (lo < hi) begin
        mid = (lo + hi) >> 1;
        if (edge_lo[mid] < a || (edge_lo[mid] == a && edge_hi[mid] < b)) lo = mid + 1;
        else hi = mid;
      end
      if (!(lo < edge_total && edge_lo[lo] == a && edge_hi[lo] == b)) begin
        r.status = pefa_pkg::ST_NOT_FOUND;
      end else begin
        len = list_len[lo];
        k = 0;
        while (k < len && slot_src[lo][k] < it.source) k++;
        hit = (k < len) && (slot_src[lo][k] == it.source);
        r.edge_index = 10'(lo);
        if (it.op == pefa_pkg::OP_READ) begin
          if (hit) begin
            r.found = 1'b1;
            r.value = slot_val[lo][k];
          end
        end else if (hit) begin
          sum = longint'($signed(slot_val[lo][k])) + longint'($signed(it.flow));
          if (sum > 64'sh7FFF_FFFF) sum = 64'sh7FFF_FFFF;
          if (sum < -64'sh8000_0000) sum = -64'sh8000_0000;
          slot_val[lo][k] = 32'(sum);
          r.value = 32'(sum);
        end else if (len >= pefa_pkg::SlotsPerEdge) begin
          r.status = pefa_pkg::ST_LIST_FULL;
        end else begin
          for (int j = len; j > k; j--) begin
            slot_src[lo][j] = slot_src[lo][j-1];
            slot_val[lo][j] = slot_val[lo][j-1];
          end
          slot_src[lo][k] = it.source;
          slot_val[lo][k] = it.flow;
          list_len[lo] = len + 1;
          r.value = it.flow;
        end
      end
    end
    return r;
  endfunction

  function automatic flow_item_t make_item(pefa_pkg::op_t op, int a, int b, int s,
                                           logic [31:0] f);
    flow_item_t it;
    it.op = op;
    it.node_a = 8'(a);
    it.node_b = 8'(b);
    it.source = 8'(s);
    it.flow = f;
    return it;
  endfunction

  function automatic flow_result_t make_result(pefa_pkg::status_t st, int ei, bit fd,
                                               logic [31:0] v);
    flow_result_t r;
    r.status = st;
    r.edge_index = 10'(ei);
    r.found = fd;
    r.value = v;
    return r;
  endfunction

  function automatic flow_item_t ascending_load();
    int a;
    int b;
    next_key += $urandom_range(1, 8);
    a = (next_key >> 8) & 255;
    b = next_key & 255;
    if (b < a) begin
      b = a;
      next_key = a * 256 + a;
    end
    if ($urandom_range(1))
      return make_item(pefa_pkg::OP_LOAD, b, a, $urandom_range(255), $urandom());
    return make_item(pefa_pkg::OP_LOAD, a, b, $urandom_range(255), $urandom());
  endfunction

  function automatic logic [31:0] random_flow();
    case ($urandom_range(3))
      0: return $urandom();
      1: return 32'($signed($urandom_range(32'h80000)) - 32'sh40000);
      2: case ($urandom_range(3))
           0: return 32'h7FFF_FFFF;
           1: return 32'h8000_0000;
           2: return 32'h0;
           default: return 32'hFFFF_FFFF;
         endcase
      default: return 32'($urandom_range(32'h30000));
    endcase
  endfunction

  function automatic flow_item_t random_item();
    int r;
    int e;
    int s;
    int n;
    flow_item_t it;
    r = $urandom_range(99);
    if (r < 8 || edge_total == 0) begin
      if ($urandom_range(15) == 0)
        return make_item(pefa_pkg::OP_LOAD, $urandom_range(255), $urandom_range(255), 0,
                         $urandom());
      return ascending_load();
    end
    if (r < 9) return make_item(pefa_pkg::OP_SCALE, $urandom_range(255), $urandom_range(255),
                                $urandom_range(255), $urandom());
    if (r >= 92) return make_item(r < 96 ? pefa_pkg::OP_ADD : pefa_pkg::OP_READ,
                                  $urandom_range(255), $urandom_range(255),
                                  $urandom_range(255), $urandom());
    n = (edge_total < HotEdges) ? edge_total : HotEdges;
    e = $urandom_range(n - 1);
    case ($urandom_range(5))
      0, 1: s = edge_lo[e];
      2, 3: s = edge_hi[e];
      4: s = $urandom_range(20);
      default: s = $urandom_range(255);
    endcase
    it = make_item(r < 62 ? pefa_pkg::OP_ADD : pefa_pkg::OP_READ, edge_lo[e], edge_hi[e], s,
                   random_flow());
    if ($urandom_range(1)) begin
      it.node_a = edge_hi[e];
      it.node_b = edge_lo[e];
    end
    return it;
  endfunction

  task automatic send_item(flow_item_t it, bit typed, flow_result_t want);
    flow_result_t p;
    if (!no_idle && $urandom_range(99) < 26) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_tdata = {6'b0, it};
    in_tvalid = 1'b1;
    do @(posedge clk); while (!in_tready);
    p = apply_item(it);
    expected_results.insert(expected_results.size(), typed ? want : p);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic send_random(int count);
    for (int i = 0; i < count; i++) send_item(random_item(), 1'b0, '0);
  endtask

  task automatic drain();
    in_tvalid = 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
  endtask

  task automatic add_row(flow_item_t it, bit typed, flow_result_t want);
    table_row_t row;
    row.item = it;
    row.typed = typed;
    row.want = want;
    directed_rows.insert(directed_rows.size(), row);
  endtask

  always @(negedge clk) begin
    if (hold_req) begin
      hold_cnt = 300;
      hold_req = 1'b0;
    end
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt--;
      out_tready <= 1'b0;
    end else if (no_idle) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(99) >= 26);
    end
  end

  always @(posedge clk) begin
    flow_result_t got;
    flow_result_t want;
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= WatchdogLimit) begin
      $display("%0t: watchdog expired, %0d results outstanding", $time, expected_results.size());
      $display("== FAIL ==");
      $finish;
    end
    if (rst_n && out_tvalid && out_tready) begin
      got = flow_result_t'(out_tdata[44:0]);
      results_seen++;
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
      end else begin
        want = expected_results.pop_front();
        if (got.status !== want.status) begin
          errors++;
          $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
        end
        if (got.edge_index !== want.edge_index) begin
          errors++;
          $display("%0t: edge_index expected %0d actual %0d", $time,
                   want.edge_index, got.edge_index);
        end
        if (got.found !== want.found) begin
          errors++;
          $display("%0t: found expected %0d actual %0d", $time, want.found, got.found);
        end
        if (got.value !== want.value) begin
          errors++;
          $display("%0t: value expected %h actual %h", $time, want.value, got.value);
        end
      end
    end
  end

  initial begin
    edge_total = 0;
    for (int e = 0; e < pefa_pkg::MaxEdges; e++) list_len[e] = 0;
    add_row(make_item(pefa_pkg::OP_READ, 1, 2, 1, 0), 1,
            make_result(pefa_pkg::ST_NOT_FOUND, 0, 0, 0));
    add_row(make_item(pefa_pkg::OP_ADD, 9, 9, 9, 32'h1234), 1,
            make_result(pefa_pkg::ST_NOT_FOUND, 0, 0, 0));
    add_row(make_item(pefa_pkg::OP_SCALE, 0, 0, 0, 0), 1, make_result(pefa_pkg::ST_OK, 0, 0, 0));
    add_row(make_item(pefa_pkg::OP_LOAD, 0, 0, 0, 0), 1, make_result(pefa_pkg::ST_OK, 0, 0, 0));
    add_row(make_item(pefa_pkg::OP_LOAD, 255, 0, 255, 32'hFFFF_FFFF), 1,
            make_result(pefa_pkg::ST_OK, 1, 0, 0));
    add_row(make_item(pefa_pkg::OP_LOAD, 2, 1, 0, 0), 1, make_result(pefa_pkg::ST_OK, 2, 0, 0));
    add_row(make_item(pefa_pkg::OP_LOAD, 3, 4, 0, 0), 1, make_result(pefa_pkg::ST_OK, 3, 0, 0));
    add_row(make_item(pefa_pkg::OP_ADD, 1, 2, 1, 32'h7FFF_FFFF), 1,
            make_result(pefa_pkg::ST_OK, 2, 0, 32'h7FFF_FFFF));
    add_row(make_item(pefa_pkg::OP_ADD, 2, 1, 1, 32'h1), 1,
            make_result(pefa_pkg::ST_OK, 2, 0, 32'h7FFF_FFFF));
    add_row(make_item(pefa_pkg::OP_ADD, 1, 2, 2, 32'h8000_0000), 1,
            make_result(pefa_pkg::ST_OK, 2, 0, 32'h8000_0000));
    add_row(make_item(pefa_pkg::OP_ADD, 1, 2, 2, 32'hFFFF_FFFF), 1,
            make_result(pefa_pkg::ST_OK, 2, 0, 32'h8000_0000));
    add_row(make_item(pefa_pkg::OP_READ, 2, 1, 1, 0), 1,
            make_result(pefa_pkg::ST_OK, 2, 1, 32'h7FFF_FFFF));
    add_row(make_item(pefa_pkg::OP_READ, 1, 2, 7, 0), 1, make_result(pefa_pkg::ST_OK, 2, 0, 0));
    add_row(make_item(pefa_pkg::OP_READ, 0, 0, 0, 0), 1, make_result(pefa_pkg::ST_OK, 0, 0, 0));
    add_row(make_item(pefa_pkg::OP_ADD, 0, 255, 0, 32'h0001_0000), 0, '0);
    add_row(make_item(pefa_pkg::OP_ADD, 255, 0, 255, 32'hFFFE_0000), 0, '0);
    add_row(make_item(pefa_pkg::OP_ADD, 0, 255, 77, 32'h0000_8000), 0, '0);
    add_row(make_item(pefa_pkg::OP_ADD, 0, 0, 0, 32'h0003_0000), 0, '0);
    add_row(make_item(pefa_pkg::OP_SCALE, 5, 6, 7, 32'hFFFF_FFFF), 0, '0);
    add_row(make_item(pefa_pkg::OP_READ, 0, 255, 0, 0), 0, '0);
    add_row(make_item(pefa_pkg::OP_READ, 255, 0, 255, 0), 0, '0);
    add_row(make_item(pefa_pkg::OP_READ, 0, 0, 0, 0), 0, '0);
    add_row(make_item(pefa_pkg::OP_READ, 1, 2, 2, 0), 0, '0);

    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_rows[i])
      send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].want);
    for (int s = 40; s > 24; s--)
      send_item(make_item(pefa_pkg::OP_ADD, 4, 3, s, random_flow()), 1'b0, '0);
    send_item(make_item(pefa_pkg::OP_ADD, 3, 4, 99, 32'h100), 1'b1,
              make_result(pefa_pkg::ST_LIST_FULL, 3, 0, 0));
    send_item(make_item(pefa_pkg::OP_READ, 3, 4, 33, 0), 1'b0, '0);

    send_random(400);
    hold_req = 1'b1;
    send_random(30);
    drain();
    no_idle = 1'b1;
    send_random(150);
    no_idle = 1'b0;
    send_random(240);

    while (edge_total < pefa_pkg::MaxEdges) send_item(ascending_load(), 1'b0, '0);
    repeat (3)
      send_item(make_item(pefa_pkg::OP_LOAD, $urandom_range(255), $urandom_range(255), 0, 0),
                1'b1, make_result(pefa_pkg::ST_TABLE_FULL, 0, 0, 0));
    send_random(20);
    send_item(make_item(pefa_pkg::OP_SCALE, 0, 0, 0, 0), 1'b0, '0);
    send_random(10);

    drain();
    repeat (200) @(negedge clk);
    if (expected_results.size() != 0) begin
      errors++;
      $display("%0t: %0d expected results never arrived", $time, expected_results.size());
    end
    $display("Sent %0d transactions (loads to table full, adds, reads, scales), %0d results checked",
             items_sent, results_seen);
    $display("Included a 300-cycle receiver hold-off, a sender drain pause and a no-idle stretch");
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[filelist.f]
hdl/pefa_pkg.sv
hdl/pefa_ram.sv
hdl/pefa_div.sv
hdl/per_edge_flow_accumulator_top.sv
sim/per_edge_flow_accumulator_top_tb.sv
